// File: src/efe_pkg.sv
// Shared types, constants and the level table for the exponential fade envelope.
// No dependencies; efe_dp, efe_ctrl and the top level refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package efe_pkg;

    localparam int TABLE_BITS = 6;
    localparam int TIME_BITS  = 32;
    localparam int SHIFT_W    = 40;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int LEVEL_W    = 16;
    localparam int FRAC_W     = 16;

    localparam int LEVELS     = 1 << TABLE_BITS;
    localparam int IDX_W      = TABLE_BITS + 1;
    localparam int DIV_STEPS  = TABLE_BITS + FRAC_W;
    localparam int QUO_W      = DIV_STEPS + 1;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [63:0] Q31_ONE   = 64'd1 << 31;
    localparam logic [63:0] LN100_Q31 = 64'd9889527671;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [SHIFT_W-1:0]   t_shift;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [LEVELS:0][LEVEL_W-1:0] t_level_table;

    typedef enum logic [1:0] {
        KIND_UPDATE   = 2'd0,
        KIND_FREEZE   = 2'd1,
        KIND_UNFREEZE = 2'd2,
        KIND_SET_IN   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        SH_NONE      = 2'd0,
        SH_SUB_NOW   = 2'd1,
        SH_ADD_NOW   = 2'd2,
        SH_ADD_DELTA = 2'd3
    } t_shift_op;

    typedef enum logic [1:0] {
        LV_HOLD  = 2'd0,
        LV_ZERO  = 2'd1,
        LV_FULL  = 2'd2,
        LV_CURVE = 2'd3
    } t_lvl_op;

    typedef struct packed {
        logic      load;
        logic      eff;
        logic      sel;
        logic      t_zero;
        t_shift_op sh_op;
        logic      div_init;
        logic      div_step;
        logic      lut;
        logic      mul;
        t_lvl_op   lvl_op;
        logic      out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic past_end;
        logic curve;
        logic full;
        logic set_ok;
    } t_dp_sts;

    // e^(-z), z and result in Q31; elaboration only
    function automatic logic [63:0] exp_neg_q31(input logic [63:0] z);
        logic [63:0] w;
        logic [63:0] term;
        logic [63:0] sum;
        w    = z >> 3;
        term = Q31_ONE;
        sum  = Q31_ONE;
        for (int k = 1; k <= 14; k++) begin
            term = ((term * w) >> 31) / 64'(k);
            if ((k & 1) != 0) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        for (int s = 0; s < 3; s++) begin
            sum = (sum * sum) >> 31;
        end
        return sum;
    endfunction

    function automatic t_level_table build_level_table();
        t_level_table tbl;
        logic [63:0]  z;
        logic [63:0]  v;
        for (int i = 0; i <= LEVELS; i++) begin
            z = (LN100_Q31 * 64'(i)) / 64'(LEVELS);
            v = (exp_neg_q31(z) + 64'd16384) >> 15;
            tbl[i] = (v > 64'd65535) ? 16'hFFFF : v[LEVEL_W-1:0];
        end
        return tbl;
    endfunction

    localparam t_level_table LEVEL_TABLE = build_level_table();

    // register moved by the sign-extended shift, wrapped to the time width
    function automatic t_time eff_time(input logic [CFG_W-1:0] cfg, input t_shift sh);
        logic [47:0] sx;
        sx = {{(48 - SHIFT_W){sh[SHIFT_W-1]}}, sh};
        return t_time'(48'(cfg) + sx);
    endfunction

endpackage

`default_nettype wire

// File: src/efe_in_if.sv
// Input channel: kind and current time with valid/ready.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface efe_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] current_time;

    modport source (output valid, output kind, output current_time, input ready);
    modport sink   (input valid, input kind, input current_time, output ready);
endinterface

`default_nettype wire

// File: src/efe_out_if.sv
// Result channel: fade level, level valid flag and active flag with valid/ready.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface efe_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] fade_level;
    logic        level_valid;
    logic        active;

    modport source (output valid, output fade_level, output level_valid, output active,
                    input ready);
    modport sink   (input valid, input fade_level, input level_valid, input active,
                    output ready);
endinterface

`default_nettype wire

// File: src/efe_cfg_if.sv
// Configuration write channel: register index and data with valid/ready.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface efe_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/efe_dp.sv
// Datapath: config registers, time shift, phase compare, restoring divider,
// table interpolation and the output level register. Uses efe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module efe_dp (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire efe_pkg::t_dp_cmd                      i_cmd,
    output efe_pkg::t_dp_sts                           o_sts,
    input  wire logic [31:0]                           i_current_time,
    input  wire logic                                  i_cfg_we,
    input  wire logic [efe_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [efe_pkg::CFG_W-1:0]             i_cfg_data,
    output logic [efe_pkg::LEVEL_W-1:0]                o_fade_level
);

    logic [efe_pkg::CFG_W-1:0] r_cfg [4];
    efe_pkg::t_shift           r_shift;

    efe_pkg::t_time r_now;
    efe_pkg::t_time r_fis, r_fie, r_fos, r_foe;
    efe_pkg::t_time r_num, r_den;
    logic [efe_pkg::TIME_BITS:0]     r_rem;
    logic [efe_pkg::QUO_W-1:0]       r_quo;
    logic [efe_pkg::LEVEL_W-1:0]     r_hi, r_lo, r_level, r_out_level;
    logic [efe_pkg::FRAC_W-1:0]      r_fr;
    logic [31:0]                     r_prod;

    efe_pkg::t_time                  t_set;
    efe_pkg::t_time                  delta;
    logic                            gt_fis, ge_fie, gt_fos, gt_foe;
    logic [efe_pkg::TIME_BITS:0]     rem_sh;
    logic [efe_pkg::TIME_BITS:0]     num_x, den_x;
    efe_pkg::t_idx                   idx, idx_hi, idx_lo;
    logic                            sat;
    logic [31:0]                     rounded;

    // phase decision
    always_comb begin
        gt_foe = r_now > r_foe;
        gt_fos = r_now > r_fos;
        ge_fie = r_now >= r_fie;
        gt_fis = r_now > r_fis;
        t_set  = i_cmd.t_zero ? '0 : r_now;
        delta  = t_set - r_fie;
        o_sts.past_end = gt_foe;
        o_sts.curve    = !gt_foe && (gt_fos || (!ge_fie && gt_fis));
        o_sts.full     = !gt_fos && ge_fie;
        o_sts.set_ok   = (t_set > r_fie) && (t_set <= r_fos);
    end

    always_comb begin
        num_x  = {1'b0, r_num};
        den_x  = {1'b0, r_den};
        rem_sh = {r_rem[efe_pkg::TIME_BITS-1:0], 1'b0};
        idx    = r_quo[efe_pkg::QUO_W-1:efe_pkg::FRAC_W];
        sat    = idx >= efe_pkg::IDX_W'(efe_pkg::LEVELS);
        idx_hi = sat ? efe_pkg::IDX_W'(efe_pkg::LEVELS) : idx;
        idx_lo = sat ? efe_pkg::IDX_W'(efe_pkg::LEVELS) : idx + 1'b1;
        rounded = (r_prod + 32'h0000_8000) >> 16;
    end

    // architectural state: reset to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_cfg[i] <= '0;
            end
            r_shift <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg[i_cfg_index] <= i_cfg_data;
            end
            unique case (i_cmd.sh_op)
                efe_pkg::SH_NONE:      r_shift <= r_shift;
                efe_pkg::SH_SUB_NOW:   r_shift <= r_shift - efe_pkg::SHIFT_W'(r_now);
                efe_pkg::SH_ADD_NOW:   r_shift <= r_shift + efe_pkg::SHIFT_W'(r_now);
                efe_pkg::SH_ADD_DELTA: r_shift <= r_shift + efe_pkg::SHIFT_W'(delta);
                default:               r_shift <= r_shift;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now <= efe_pkg::t_time'(48'(i_current_time));
        end
        if (i_cmd.eff) begin
            r_fis <= efe_pkg::eff_time(r_cfg[0], r_shift);
            r_fie <= efe_pkg::eff_time(r_cfg[1], r_shift);
            r_fos <= efe_pkg::eff_time(r_cfg[2], r_shift);
            r_foe <= efe_pkg::eff_time(r_cfg[3], r_shift);
        end
        if (i_cmd.sel) begin
            if (gt_fos) begin
                r_num <= r_now - r_fos;
                r_den <= r_foe - r_fos;
            end else begin
                r_num <= r_fie - r_now;
                r_den <= r_fie - r_fis;
            end
        end
        if (i_cmd.div_init) begin
            if (num_x >= den_x) begin
                r_rem <= num_x - den_x;
                r_quo <= efe_pkg::QUO_W'(1);
            end else begin
                r_rem <= num_x;
                r_quo <= '0;
            end
        end else if (i_cmd.div_step) begin
            if (rem_sh >= den_x) begin
                r_rem <= rem_sh - den_x;
                r_quo <= {r_quo[efe_pkg::QUO_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[efe_pkg::QUO_W-2:0], 1'b0};
            end
        end
        if (i_cmd.lut) begin
            r_hi <= efe_pkg::LEVEL_TABLE[idx_hi];
            r_lo <= efe_pkg::LEVEL_TABLE[idx_lo];
            r_fr <= r_quo[efe_pkg::FRAC_W-1:0];
        end
        if (i_cmd.mul) begin
            r_prod <= 32'(r_hi - r_lo) * 32'(r_fr);
        end
        unique case (i_cmd.lvl_op)
            efe_pkg::LV_HOLD:  r_level <= r_level;
            efe_pkg::LV_ZERO:  r_level <= '0;
            efe_pkg::LV_FULL:  r_level <= '1;
            efe_pkg::LV_CURVE: r_level <= r_hi - rounded[efe_pkg::LEVEL_W-1:0];
            default:           r_level <= r_level;
        endcase
        if (i_cmd.out_load) begin
            r_out_level <= r_level;
        end
    end

    assign o_fade_level = r_out_level;

endmodule

`default_nettype wire

// File: src/efe_ctrl.sv
// Controller: sequences one item through the datapath, holds frozen/retired
// and the output handshake. Uses efe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module efe_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [1:0]        i_kind,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic                   o_out_level_valid,
    output logic                   o_out_active,
    output efe_pkg::t_dp_cmd       o_cmd,
    input  wire efe_pkg::t_dp_sts  i_sts
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_EFF  = 9'b000000010,
        S_SEL  = 9'b000000100,
        S_DIV0 = 9'b000001000,
        S_DIV  = 9'b000010000,
        S_LUT  = 9'b000100000,
        S_MUL  = 9'b001000000,
        S_FIN  = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    t_state                     r_state, n_state;
    efe_pkg::t_kind             r_kind, n_kind;
    logic                       r_frozen, n_frozen;
    logic                       r_retired, n_retired;
    logic                       r_lvl_valid, n_lvl_valid;
    logic                       r_out_valid, n_out_valid;
    logic                       r_out_lvl_valid, n_out_lvl_valid;
    logic                       r_out_active, n_out_active;
    logic [efe_pkg::CNT_W-1:0]  r_cnt, n_cnt;

    always_comb begin
        n_state         = r_state;
        n_kind          = r_kind;
        n_frozen        = r_frozen;
        n_retired       = r_retired;
        n_lvl_valid     = r_lvl_valid;
        n_out_valid     = r_out_valid;
        n_out_lvl_valid = r_out_lvl_valid;
        n_out_active    = r_out_active;
        n_cnt           = r_cnt;
        o_cmd           = '0;
        o_cmd.sh_op     = efe_pkg::SH_NONE;
        o_cmd.lvl_op    = efe_pkg::LV_HOLD;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_kind     = efe_pkg::t_kind'(i_kind);
                    n_state    = S_EFF;
                end
            end
            S_EFF: begin
                o_cmd.eff = 1'b1;
                n_state   = S_SEL;
            end
            S_SEL: begin
                o_cmd.sel    = 1'b1;
                o_cmd.t_zero = r_frozen;
                o_cmd.lvl_op = efe_pkg::LV_ZERO;
                n_lvl_valid  = 1'b0;
                n_state      = S_DONE;
                unique case (r_kind)
                    efe_pkg::KIND_UPDATE: begin
                        if (r_retired || r_frozen) begin
                            n_lvl_valid = 1'b0;
                        end else if (i_sts.past_end) begin
                            n_retired = 1'b1;
                        end else if (i_sts.curve) begin
                            n_lvl_valid  = 1'b1;
                            o_cmd.lvl_op = efe_pkg::LV_HOLD;
                            n_state      = S_DIV0;
                        end else begin
                            n_lvl_valid  = 1'b1;
                            o_cmd.lvl_op = i_sts.full ? efe_pkg::LV_FULL : efe_pkg::LV_ZERO;
                        end
                    end
                    efe_pkg::KIND_FREEZE: begin
                        if (!r_frozen) begin
                            n_frozen    = 1'b1;
                            o_cmd.sh_op = efe_pkg::SH_SUB_NOW;
                        end
                    end
                    efe_pkg::KIND_UNFREEZE: begin
                        if (r_frozen) begin
                            n_frozen    = 1'b0;
                            o_cmd.sh_op = efe_pkg::SH_ADD_NOW;
                        end
                    end
                    efe_pkg::KIND_SET_IN: begin
                        if (i_sts.set_ok) begin
                            o_cmd.sh_op = efe_pkg::SH_ADD_DELTA;
                        end
                    end
                    default: n_lvl_valid = 1'b0;
                endcase
            end
            S_DIV0: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == efe_pkg::CNT_W'(efe_pkg::DIV_STEPS - 1)) begin
                    n_state = S_LUT;
                end
            end
            S_LUT: begin
                o_cmd.lut = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                o_cmd.lvl_op = efe_pkg::LV_CURVE;
                n_state      = S_DONE;
            end
            S_DONE: begin
                // result slot is free or being emptied this cycle
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load  = 1'b1;
                    n_out_valid     = 1'b1;
                    n_out_lvl_valid = r_lvl_valid;
                    n_out_active    = !r_retired;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_kind          <= efe_pkg::KIND_UPDATE;
            r_frozen        <= 1'b0;
            r_retired       <= 1'b0;
            r_lvl_valid     <= 1'b0;
            r_out_valid     <= 1'b0;
            r_out_lvl_valid <= 1'b0;
            r_out_active    <= 1'b1;
            r_cnt           <= '0;
        end else begin
            r_state         <= n_state;
            r_kind          <= n_kind;
            r_frozen        <= n_frozen;
            r_retired       <= n_retired;
            r_lvl_valid     <= n_lvl_valid;
            r_out_valid     <= n_out_valid;
            r_out_lvl_valid <= n_out_lvl_valid;
            r_out_active    <= n_out_active;
            r_cnt           <= n_cnt;
        end
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_out_level_valid = r_out_lvl_valid;
    assign o_out_active      = r_out_active;

endmodule

`default_nettype wire

// File: src/exp_fade_envelope_core.sv
// Exponential fade envelope, top level: controller plus datapath.
// Uses efe_pkg, efe_in_if, efe_out_if, efe_cfg_if, efe_ctrl and efe_dp.
//
// Channels: i_in takes one word (kind, current_time) per item; o_out gives
// exactly one word (fade_level, level_valid, active) per item; i_cfg writes
// fade_in_start/fade_in_end/fade_out_start/fade_out_end at index 0..3 and is
// always ready. Write configuration only while no item is in flight.
// Sequence: an update in fade-in or fade-out runs the restoring divider, one
// quotient bit per cycle (TABLE_BITS+16 steps after a first compare), then table
// read, multiply and interpolate before the result goes to the output register.
// All other items go from the phase decision straight to the output register.
// A new word is accepted at the edge after the previous result is loaded into the
// output register, so only one item is in flight at a time.
// Stall: the result waits in the output register while o_out.ready is low;
// the next item is still accepted and runs up to its result, then holds.
// Reset (synchronous, active low) clears the registers, time shift, frozen
// and retired flags; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module exp_fade_envelope_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    efe_in_if.sink     i_in,
    efe_out_if.source  o_out,
    efe_cfg_if.sink    i_cfg
);

    efe_pkg::t_dp_cmd cmd;
    efe_pkg::t_dp_sts sts;
    logic             cfg_we;

    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid && i_cfg.ready;

    efe_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in.valid),
        .o_in_ready        (i_in.ready),
        .i_kind            (i_in.kind),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_out_level_valid (o_out.level_valid),
        .o_out_active      (o_out.active),
        .o_cmd             (cmd),
        .i_sts             (sts)
    );

    efe_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_current_time (i_in.current_time),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .o_fade_level   (o_out.fade_level)
    );

`ifndef SYNTHESIS
    // one item at a time: accept drops ready for the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while an item is in flight");

    // a computed level never comes from a retired envelope
    a_level_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.level_valid) |-> o_out.active)
        else $error("level valid on a retired envelope");

    // no level computed means level is zero
    a_zero_when_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.level_valid) |-> (o_out.fade_level == 16'd0))
        else $error("nonzero level without level_valid");

    // retirement is permanent
    a_retired_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.active) |=> !o_out.active)
        else $error("envelope came back from retirement");
`endif

endmodule

`default_nettype wire
